[hdl/fnvbc_pkg.sv]
// fnvbc_pkg: shared types, constants and the fnv-1a byte step for the pixel hash block
// used by fnvbc_ctrl, fnvbc_dp and pixel_fnv_hash_black_count; no dependencies
`timescale 1ns / 1ps

package fnvbc_pkg;

	localparam int unsigned HASH_W          = 64;
	localparam int unsigned TALLY_W         = 16;
	localparam int unsigned CHAN_W          = 8;
	localparam int unsigned BYTES_PER_PIXEL = 4;
	localparam int unsigned PIXEL_W         = CHAN_W * BYTES_PER_PIXEL;
	localparam int unsigned BYTE_IDX_W      = $clog2(BYTES_PER_PIXEL);
	localparam int unsigned OUT_DATA_W      = 104;

	localparam logic [HASH_W-1:0]     FNV_BASIS         = 64'hcbf29ce484222325;
	localparam logic [CHAN_W-1:0]     BLACK_LEVEL_RESET = 8'd16;
	localparam logic [TALLY_W-1:0]    TALLY_MAX         = 16'hffff;
	localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX     = BYTE_IDX_W'(BYTES_PER_PIXEL - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_EMIT
	} fnvbc_state_t;

	typedef struct packed {
		logic                  load;
		logic                  step;
		logic                  emit;
		logic [BYTE_IDX_W-1:0] byte_sel;
	} fnvbc_cmd_t;

	// xor one byte in, then multiply by the prime 2^40 + 0x1b3 modulo 2^64
	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
			input logic [CHAN_W-1:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-CHAN_W){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
		return (v == TALLY_MAX) ? TALLY_MAX : v + TALLY_W'(1);
	endfunction

endpackage

[hdl/fnvbc_ctrl.sv]
// fnvbc_ctrl: controller fsm sequencing the four byte steps, frame end and output word
// depends on fnvbc_pkg
`timescale 1ns / 1ps

module fnvbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output fnvbc_pkg::fnvbc_cmd_t cmd
);
	import fnvbc_pkg::*;

	fnvbc_state_t          state_q, state_d;
	logic [BYTE_IDX_W-1:0] idx_q, idx_d;
	logic                  last_q;
	logic                  out_valid_q, out_valid_d;
	logic                  accept;
	logic                  emit;

	assign s_tready = (state_q == ST_IDLE) ||
		((state_q == ST_HASH) && (idx_q == LAST_BYTE_IDX) && !last_q);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		emit         = 1'b0;
		cmd.load     = accept;
		cmd.step     = 1'b0;
		cmd.emit     = 1'b0;
		cmd.byte_sel = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HASH;
					idx_d   = '0;
				end
			end
			ST_HASH: begin
				cmd.step = 1'b1;
				idx_d    = idx_q + BYTE_IDX_W'(1);
				if (idx_q == LAST_BYTE_IDX) begin
					if (last_q) begin
						state_d = ST_EMIT;
					end else if (accept) begin
						state_d = ST_HASH;
						idx_d   = '0;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				emit = !out_valid_q || m_tready;
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.emit = emit;
		if (emit) begin
			out_valid_d = 1'b1;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
			if (accept) begin
				last_q <= s_tlast;
			end
		end
	end

endmodule

[hdl/fnvbc_dp.sv]
// fnvbc_dp: datapath with pixel register, running hash, saturating tallies and output word
// depends on fnvbc_pkg
`timescale 1ns / 1ps

module fnvbc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fnvbc_pkg::fnvbc_cmd_t         cmd,
	input  logic [fnvbc_pkg::PIXEL_W-1:0] pixel,
	input  logic                          cfg_we,
	input  logic [fnvbc_pkg::CHAN_W-1:0]  cfg_data,
	output logic [fnvbc_pkg::HASH_W-1:0]  hash_out,
	output logic [fnvbc_pkg::TALLY_W-1:0] black_out,
	output logic [fnvbc_pkg::TALLY_W-1:0] total_out,
	output logic                          all_black_out
);
	import fnvbc_pkg::*;

	logic [PIXEL_W-1:0] pix_q;
	logic [CHAN_W-1:0]  black_level_q;
	logic [HASH_W-1:0]  hash_q;
	logic [TALLY_W-1:0] black_tally_q;
	logic [TALLY_W-1:0] pixel_tally_q;
	logic               nonblack_q;
	logic [CHAN_W-1:0]  cur_byte;
	logic               is_black;

	assign cur_byte = pix_q[cmd.byte_sel*CHAN_W +: CHAN_W];
	assign is_black = (pixel[CHAN_W-1:0] <= black_level_q) &&
		(pixel[2*CHAN_W-1:CHAN_W] <= black_level_q) &&
		(pixel[3*CHAN_W-1:2*CHAN_W] <= black_level_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_level_q <= BLACK_LEVEL_RESET;
		end else if (cfg_we) begin
			black_level_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q        <= FNV_BASIS;
			black_tally_q <= '0;
			pixel_tally_q <= '0;
			nonblack_q    <= 1'b0;
		end else begin
			if (cmd.step) begin
				hash_q <= fnv_step(hash_q, cur_byte);
			end else if (cmd.emit) begin
				hash_q <= FNV_BASIS;
			end
			if (cmd.load) begin
				pixel_tally_q <= sat_inc(pixel_tally_q);
				if (is_black) begin
					black_tally_q <= sat_inc(black_tally_q);
				end else begin
					nonblack_q <= 1'b1;
				end
			end else if (cmd.emit) begin
				black_tally_q <= '0;
				pixel_tally_q <= '0;
				nonblack_q    <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= pixel;
		end
		if (cmd.emit) begin
			hash_out      <= hash_q;
			black_out     <= black_tally_q;
			total_out     <= pixel_tally_q;
			all_black_out <= !nonblack_q;
		end
	end

endmodule

[hdl/pixel_fnv_hash_black_count.sv]
// pixel_fnv_hash_black_count: top level, 64-bit fnv-1a frame hash with black pixel count
// depends on fnvbc_pkg, fnvbc_ctrl, fnvbc_dp
//
// channel   direction  signals                      contents
// s_        in         tvalid tready tdata tlast    pixel word, tlast marks last pixel
// m_        out        tvalid tready tdata          frame result word
// cfg_      in         we data                      black level register
//
// the hash unit does one byte step per cycle, four byte steps per pixel
// after the four byte steps of a last pixel, the emit state loads the output register, then idle
// the next pixel is taken during the fourth byte step of the current one, unless that one is last
// a result waiting on m_tready stalls only the end of the following frame
// arst_n restores the hash basis, clears both tallies and sets black level to 16
`timescale 1ns / 1ps

module pixel_fnv_hash_black_count (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [fnvbc_pkg::PIXEL_W-1:0]    s_tdata,  // chan0, chan1, chan2, chan3
	input  logic                             s_tlast,  // last_pixel
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fnvbc_pkg::OUT_DATA_W-1:0] m_tdata,  // content_hash, black_pixels,
	                                                   // total_pixels, all_black, zero pad
	input  logic                             cfg_we,
	input  logic [fnvbc_pkg::CHAN_W-1:0]     cfg_data  // black_level
);
	import fnvbc_pkg::*;

	fnvbc_cmd_t         cmd;
	logic [HASH_W-1:0]  hash_out;
	logic [TALLY_W-1:0] black_out;
	logic [TALLY_W-1:0] total_out;
	logic               all_black_out;

	fnvbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	fnvbc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.pixel         (s_tdata),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.hash_out      (hash_out),
		.black_out     (black_out),
		.total_out     (total_out),
		.all_black_out (all_black_out)
	);

	assign m_tdata = {{(OUT_DATA_W-HASH_W-2*TALLY_W-1){1'b0}},
		all_black_out, total_out, black_out, hash_out};

endmodule
